// ===== design/obudf_pkg.sv =====
// obudf_pkg: shared constants and types of the obu header deframer
// depends on nothing; used by the interfaces, the input stage and the core

package obudf_pkg;

    localparam int OFFSET_BITS_DEF    = 48;
    localparam int MAX_SIZE_BYTES_DEF = 9;
    localparam int CFG_BITS           = 48;
    localparam int COUNT_BITS         = 4;

    localparam logic [2:0] ST_OK             = 3'd0;
    localparam logic [2:0] ST_FORBIDDEN      = 3'd1;
    localparam logic [2:0] ST_TRUNC_EXT      = 3'd2;
    localparam logic [2:0] ST_BAD_SIZE       = 3'd3;
    localparam logic [2:0] ST_TRUNC_PAYLOAD  = 3'd4;

    localparam logic [3:0] OBU_FRAME_HEADER = 4'd3;
    localparam logic [3:0] OBU_FRAME        = 4'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } in_word_t;

endpackage

// ===== design/obudf_if.sv =====
// obudf_if: byte, record and configuration channels of the obu header deframer
// depends on obudf_pkg

interface obudf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface obudf_obu_if #(
    parameter int OFFSET_BITS = obudf_pkg::OFFSET_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [2:0]             status;
    logic [OFFSET_BITS-1:0] obu_offset;
    logic [OFFSET_BITS-1:0] obu_total_length;
    logic [3:0]             obu_kind;
    logic                   size_field_present;
    logic                   extension_present;
    logic [2:0]             temporal_layer;
    logic [1:0]             spatial_layer;
    logic                   frame_info_valid;
    logic                   existing_frame;
    logic [1:0]             picture_type;
    logic                   show_flag;

    modport source (
        output valid, input ready,
        output status, output obu_offset, output obu_total_length, output obu_kind,
        output size_field_present, output extension_present, output temporal_layer,
        output spatial_layer, output frame_info_valid, output existing_frame,
        output picture_type, output show_flag
    );
    modport sink (
        input valid, output ready,
        input status, input obu_offset, input obu_total_length, input obu_kind,
        input size_field_present, input extension_present, input temporal_layer,
        input spatial_layer, input frame_info_valid, input existing_frame,
        input picture_type, input show_flag
    );
endinterface

interface obudf_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [obudf_pkg::CFG_BITS-1:0] base_offset;

    modport source (output valid, output base_offset, input ready);
    modport sink (input valid, input base_offset, output ready);
endinterface

// ===== design/obudf_in_stage.sv =====
// obudf_in_stage: input register of the byte stream
// depends on obudf_pkg and obudf_if

module obudf_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    obudf_byte_if.sink          stream,
    input  logic                take,
    output logic                word_valid,
    output obudf_pkg::in_word_t word
);

    logic                valid_reg;
    logic                valid_next;
    obudf_pkg::in_word_t word_reg;
    logic                load;

    assign stream.ready = !valid_reg || take;
    assign load         = stream.valid && stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg.data_byte     <= stream.data_byte;
            word_reg.end_of_buffer <= stream.end_of_buffer;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

// ===== design/obudf_core.sv =====
// obudf_core: obu parse state, base offset register and result register
// depends on obudf_pkg and obudf_if

module obudf_core #(
    parameter int OFFSET_BITS    = obudf_pkg::OFFSET_BITS_DEF,
    parameter int MAX_SIZE_BYTES = obudf_pkg::MAX_SIZE_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    obudf_cfg_if.sink           cfg,
    input  logic                word_valid,
    input  obudf_pkg::in_word_t word,
    output logic                take,
    obudf_obu_if.source         records
);

    localparam int ACC_BITS = 7 * MAX_SIZE_BYTES;
    localparam int CB       = obudf_pkg::COUNT_BITS;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_EXT,
        PH_SIZE,
        PH_PAYLOAD,
        PH_TO_END,
        PH_SKIP
    } phase_t;

    logic [obudf_pkg::CFG_BITS-1:0] base_reg;

    phase_t                 phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [10:0]            hf_reg, hf_next;
    logic [ACC_BITS-1:0]    acc_reg, acc_next;
    logic [CB-1:0]          cnt_reg, cnt_next;
    logic [ACC_BITS-1:0]    rem_reg, rem_next;
    logic [4:0]             fb_reg, fb_next;

    logic                   out_valid_reg, out_valid_next;
    logic [2:0]             status_reg, status_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [OFFSET_BITS-1:0] length_reg, length_next;
    logic [10:0]            ohf_reg, ohf_next;
    logic [4:0]             ofb_reg, ofb_next;

    logic [7:0]             b;
    logic                   last;
    logic                   emit;
    logic                   err;
    logic [2:0]             code;
    logic [ACC_BITS-1:0]    lanes;
    logic                   frame_kind;

    assign cfg.ready = 1'b1;
    assign take      = word_valid && (!out_valid_reg || records.ready);
    assign b         = word.data_byte;
    assign last      = word.end_of_buffer;

    always_comb
    begin
        for (int i = 0; i < MAX_SIZE_BYTES; i++)
        begin
            lanes[7*i +: 7] = (cnt_reg == CB'(i)) ? b[6:0] : 7'd0;
        end
    end

    assign frame_kind = (hf_reg[3:0] inside {obudf_pkg::OBU_FRAME_HEADER, obudf_pkg::OBU_FRAME});

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        hf_next    = hf_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        fb_next    = fb_reg;
        emit       = 1'b0;
        err        = 1'b0;
        code       = obudf_pkg::ST_OK;

        case (phase_reg)
            PH_HEADER:
            begin
                start_next = pos_reg;
                acc_next   = '0;
                cnt_next   = '0;
                rem_next   = '0;
                fb_next    = '0;
                hf_next    = {5'd0, b[2], b[1], b[6:3]};
                if (b[7])
                begin
                    hf_next    = '0;
                    emit       = 1'b1;
                    err        = 1'b1;
                    code       = obudf_pkg::ST_FORBIDDEN;
                    phase_next = PH_SKIP;
                end
                else if (b[2])
                begin
                    emit       = last;
                    err        = 1'b1;
                    code       = obudf_pkg::ST_TRUNC_EXT;
                    phase_next = PH_EXT;
                end
                else if (b[1])
                begin
                    emit       = last;
                    err        = 1'b1;
                    code       = obudf_pkg::ST_BAD_SIZE;
                    phase_next = PH_SIZE;
                end
                else
                begin
                    emit       = last;
                    phase_next = PH_TO_END;
                end
            end
            PH_EXT:
            begin
                hf_next = hf_reg | {b[4:3], b[7:5], 6'd0};
                if (hf_reg[4])
                begin
                    emit       = last;
                    err        = 1'b1;
                    code       = obudf_pkg::ST_BAD_SIZE;
                    phase_next = PH_SIZE;
                end
                else
                begin
                    emit       = last;
                    phase_next = PH_TO_END;
                end
            end
            PH_SIZE:
            begin
                acc_next = acc_reg | lanes;
                cnt_next = cnt_reg + CB'(1);
                if (b[7])
                begin
                    if (last || (cnt_next >= CB'(MAX_SIZE_BYTES)))
                    begin
                        emit       = 1'b1;
                        err        = 1'b1;
                        code       = obudf_pkg::ST_BAD_SIZE;
                        phase_next = PH_SKIP;
                    end
                end
                else if (acc_next == '0)
                begin
                    emit       = 1'b1;
                    phase_next = PH_HEADER;
                end
                else if (last)
                begin
                    emit = 1'b1;
                    err  = 1'b1;
                    code = obudf_pkg::ST_TRUNC_PAYLOAD;
                end
                else
                begin
                    rem_next   = acc_next;
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD, PH_TO_END:
            begin
                if (!fb_reg[4] && frame_kind)
                begin
                    fb_next = b[7] ? 5'b11000 : {1'b1, 1'b0, b[6:5], b[4]};
                end
                if (phase_reg == PH_PAYLOAD)
                begin
                    rem_next = rem_reg - ACC_BITS'(1);
                    if (rem_next == '0)
                    begin
                        emit       = 1'b1;
                        phase_next = PH_HEADER;
                    end
                    else if (last)
                    begin
                        emit = 1'b1;
                        err  = 1'b1;
                        code = obudf_pkg::ST_TRUNC_PAYLOAD;
                    end
                end
                else
                begin
                    emit = last;
                end
            end
            default:
            begin
            end
        endcase

        if (last)
        begin
            phase_next = PH_HEADER;
            pos_next   = '0;
        end
        else
        begin
            pos_next = pos_reg + OFFSET_BITS'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        offset_next    = offset_reg;
        length_next    = length_reg;
        ohf_next       = ohf_reg;
        ofb_next       = ofb_reg;
        if (take && emit)
        begin
            out_valid_next = 1'b1;
            status_next    = err ? code : obudf_pkg::ST_OK;
            offset_next    = OFFSET_BITS'(base_reg) + start_next;
            length_next    = err ? '0 : (pos_reg - start_next + OFFSET_BITS'(1));
            ohf_next       = err ? '0 : hf_next;
            ofb_next       = err ? '0 : fb_next;
        end
        else if (records.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            phase_reg     <= PH_HEADER;
            pos_reg       <= '0;
            start_reg     <= '0;
            hf_reg        <= '0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            fb_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                base_reg <= cfg.base_offset;
            end
            if (take)
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                start_reg <= start_next;
                hf_reg    <= hf_next;
                acc_reg   <= acc_next;
                cnt_reg   <= cnt_next;
                rem_reg   <= rem_next;
                fb_reg    <= fb_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        offset_reg <= offset_next;
        length_reg <= length_next;
        ohf_reg    <= ohf_next;
        ofb_reg    <= ofb_next;
    end

    assign records.valid              = out_valid_reg;
    assign records.status             = status_reg;
    assign records.obu_offset         = offset_reg;
    assign records.obu_total_length   = length_reg;
    assign records.obu_kind           = ohf_reg[3:0];
    assign records.size_field_present = ohf_reg[4];
    assign records.extension_present  = ohf_reg[5];
    assign records.temporal_layer     = ohf_reg[8:6];
    assign records.spatial_layer      = ohf_reg[10:9];
    assign records.frame_info_valid   = ofb_reg[4];
    assign records.existing_frame     = ofb_reg[3];
    assign records.picture_type       = ofb_reg[2:1];
    assign records.show_flag          = ofb_reg[0];

endmodule

// ===== design/av1_obu_header_deframer_top.sv =====
// av1_obu_header_deframer_top: top level of the obu header deframer
// depends on obudf_pkg, obudf_if, obudf_in_stage and obudf_core

// Takes one bitstream byte per cycle and gives one record per finished OBU
// (or one error record per buffer). A byte passes an input register and the
// parse logic, and its record, if any, is loaded into the result register
// as the core takes the byte; throughput is one byte every cycle for as
// long as records are taken when offered, and a record waiting in the result
// register holds back the next byte until the record is taken.
// The user must write base_offset only while no byte is in flight; the block does not enforce this.

module av1_obu_header_deframer_top #(
    parameter int OFFSET_BITS    = obudf_pkg::OFFSET_BITS_DEF,
    parameter int MAX_SIZE_BYTES = obudf_pkg::MAX_SIZE_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    obudf_cfg_if.sink   cfg,
    obudf_byte_if.sink  stream,
    obudf_obu_if.source records
);

    logic                word_valid;
    obudf_pkg::in_word_t word;
    logic                take;

    obudf_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream),
        .take       (take),
        .word_valid (word_valid),
        .word       (word)
    );

    obudf_core #(
        .OFFSET_BITS    (OFFSET_BITS),
        .MAX_SIZE_BYTES (MAX_SIZE_BYTES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .word_valid (word_valid),
        .word       (word),
        .take       (take),
        .records    (records)
    );

endmodule
